// ===== design/cdm_pkg.sv =====
// Shared types, fixed-point constants and rounding helpers for the curvature drive mixer.
// Used by the controller, the datapath and the top level.
package cdm_pkg;

	localparam int FRAC = 14;
	localparam int ONE = 1 << FRAC;
	localparam int K065 = (65 * ONE + 50) / 100;
	localparam int K020 = (ONE + 2) / 5;
	localparam int K010 = (ONE + 5) / 10;
	localparam int KINV6 = (ONE + 3) / 6;
	localparam int KINV120 = (ONE + 60) / 120;

	localparam int DATA_W = 16;
	localparam int CFG_W = 18;
	localparam int ADDR_W = 3;
	localparam int PROD_W = 48;

	typedef enum logic [ADDR_W-1:0] {
		REG_DEADBAND = 3'd0,
		REG_DB_GAIN  = 3'd1,
		REG_LOW_SENS = 3'd2,
		REG_HIGH_SENS = 3'd3,
		REG_ANGLE    = 3'd4,
		REG_GAIN     = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_DB_T, OP_DB_S, OP_X, OP_X2, OP_X3, OP_X5, OP_T6, OP_T120,
		OP_G, OP_INERT, OP_Q1, OP_Q2, OP_A1, OP_A2, OP_MIX
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
		logic wb;
		logic mix;
	} cmd_t;

	typedef struct packed {
		logic quick;
		logic thr_small;
	} status_t;

	// Rounding right shift, ties away from zero.
	function automatic logic signed [PROD_W-1:0] rsh_frac(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		r = (mag + (PROD_W'(1) << (FRAC - 1))) >> FRAC;
		return v[PROD_W-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [PROD_W-1:0] rsh1(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		r = (mag + PROD_W'(1)) >> 1;
		return v[PROD_W-1] ? -$signed(r) : $signed(r);
	endfunction

endpackage

// ===== design/curvature_drive_mixer_unit.sv =====
// Top level of the curvature drive mixer: stream ports, configuration port,
// controller and datapath. Depends on cdm_pkg, cdm_ctrl and cdm_dp.
//
// Each drive command runs as multiply-and-round steps on the single
// shared multiplier, a multiply then a write-back each: ten always run,
// plus two for the quick-turn filter (small throttle) or sensitivity
// scaling (no quick turn), then the mix, held while the output register
// is full. One command is in flight at a time; a new one is accepted
// while a result waits. Configuration may be written only while idle.
module curvature_drive_mixer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cdm_pkg::ADDR_W-1:0]   cfg_addr,
	input  logic [cdm_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [2*cdm_pkg::DATA_W-1:0] s_tdata,  // throttle, steer
	input  logic [1:0]                   s_tuser,  // quick_turn, high_gear
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [2*cdm_pkg::DATA_W-1:0] m_tdata   // left_drive, right_drive
);
	import cdm_pkg::*;

	cmd_t    cmd;
	status_t status;

	cdm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.status(status), .cmd(cmd)
	);

	cdm_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.in_data(s_tdata), .in_user(s_tuser),
		.cmd(cmd), .status(status), .out_data(m_tdata)
	);

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384 &&
			$signed(m_tdata[15:0]) >= -16'sd16384 &&
			$signed(m_tdata[31:16]) <= 16'sd16384 &&
			$signed(m_tdata[31:16]) >= -16'sd16384))
		else $error("drive result outside plus or minus one");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a command is in progress");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a command in progress");

endmodule

// ===== design/cdm_ctrl.sv =====
// Sequencer for the curvature drive mixer: steps the shared multiplier through
// its operations and owns the stream handshakes. Depends on cdm_pkg.
module cdm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  cdm_pkg::status_t status,
	output cdm_pkg::cmd_t    cmd
);
	import cdm_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_MIX} state_t;

	state_t state_q;
	op_t    op_q;
	logic   wb_q;
	op_t    next_op;
	logic   mix_go;

	assign s_tready = (state_q == S_IDLE);
	assign mix_go = (state_q == S_MIX) && (!m_tvalid || m_tready);

	always_comb begin
		unique case (op_q)
			OP_DB_T:  next_op = OP_DB_S;
			OP_DB_S:  next_op = OP_X;
			OP_X:     next_op = OP_X2;
			OP_X2:    next_op = OP_X3;
			OP_X3:    next_op = OP_X5;
			OP_X5:    next_op = OP_T6;
			OP_T6:    next_op = OP_T120;
			OP_T120:  next_op = OP_G;
			OP_G:     next_op = OP_INERT;
			OP_INERT: next_op = status.quick ? (status.thr_small ? OP_Q1 : OP_MIX) : OP_A1;
			OP_Q1:    next_op = OP_Q2;
			OP_A1:    next_op = OP_A2;
			default:  next_op = OP_MIX;
		endcase
	end

	always_comb begin
		cmd.load = s_tvalid && s_tready;
		cmd.op = op_q;
		cmd.wb = wb_q && (state_q == S_RUN);
		cmd.mix = mix_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_DB_T;
			wb_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q <= OP_DB_T;
						wb_q <= 1'b0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (!wb_q) begin
						wb_q <= 1'b1;
					end else begin
						wb_q <= 1'b0;
						op_q <= next_op;
						if (next_op == OP_MIX) state_q <= S_MIX;
					end
				end
				S_MIX: begin
					if (mix_go) begin
						m_tvalid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/cdm_dp.sv =====
// Datapath of the curvature drive mixer: configuration registers, state,
// one shared multiplier with accumulate and rounding, and the final mixer.
// Depends on cdm_pkg.
module cdm_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cdm_pkg::ADDR_W-1:0]   cfg_addr,
	input  logic [cdm_pkg::CFG_W-1:0]    cfg_data,
	input  logic [2*cdm_pkg::DATA_W-1:0] in_data,
	input  logic [1:0]                   in_user,
	input  cdm_pkg::cmd_t                cmd,
	output cdm_pkg::status_t             status,
	output logic [2*cdm_pkg::DATA_W-1:0] out_data
);
	import cdm_pkg::*;

	logic [13:0] deadband_q;
	logic [14:0] db_gain_q, low_sens_q, high_sens_q, angle_q;
	logic [17:0] gain_q;

	logic signed [15:0] prev_q;
	logic signed [21:0] ia_q;
	logic signed [17:0] qs_q;

	logic signed [15:0] thr_c_q, trn_c_q, thr_q, trn_q;
	logic quick_q, high_q;
	logic signed [17:0] ninert_q, x_q, x2_q;
	logic signed [18:0] x3_q, t6_q, s_q;
	logic signed [20:0] x5_q, sh_q;
	logic signed [23:0] trn2_q, t_q;
	logic signed [25:0] ang_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [15:0] left_q, right_q;

	logic signed [24:0] mul_a;
	logic signed [19:0] mul_b;
	logic acc_en;
	logic signed [PROD_W-1:0] rnd;
	logic [15:0] mag_thr, mag_trn, mag_cur;
	logic db_zero;
	logic signed [PROD_W-1:0] db_r;
	logic signed [15:0] db_val, db_src;
	logic [4:0] halves;
	logic signed [23:0] ia_sum;
	logic signed [21:0] ia_new;
	logic signed [15:0] lim;
	logic signed [PROD_W-1:0] q_r;
	logic signed [26:0] lft, rgt;
	logic signed [15:0] in_thr, in_trn;

	assign in_thr = $signed(in_data[15:0]);
	assign in_trn = $signed(in_data[31:16]);
	assign mag_thr = thr_q[15] ? 16'(-thr_q) : 16'(thr_q);
	assign mag_trn = trn_q[15] ? 16'(-trn_q) : 16'(trn_q);
	assign status.quick = quick_q;
	assign status.thr_small = (mag_thr < 16'(K020));
	assign out_data = {right_q, left_q};

	function automatic logic signed [15:0] clamp_one(input logic signed [15:0] v);
		if (v > 16'sd16384) return 16'(ONE);
		if (v < -16'sd16384) return 16'(-ONE);
		return v;
	endfunction

	always_comb begin
		if (trn2_q > 24'sd16384) lim = 16'(ONE);
		else if (trn2_q < -24'sd16384) lim = 16'(-ONE);
		else lim = trn2_q[15:0];
	end

	// Gear and direction dependent inertia scalar, in halves.
	always_comb begin
		if (high_q) halves = 5'd10;
		else if ((sh_q > 0 && ninert_q > 0) || (sh_q < 0 && ninert_q < 0)) halves = 5'd5;
		else if ((sh_q[20] ? -sh_q : sh_q) > 21'sd10650) halves = 5'd10;
		else halves = 5'd6;
	end

	always_comb begin
		db_src = (cmd.op == OP_DB_T) ? thr_c_q : trn_c_q;
		mag_cur = db_src[15] ? 16'(-db_src) : 16'(db_src);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		acc_en = 1'b0;
		case (cmd.op)
			OP_DB_T, OP_DB_S: begin
				mul_a = 25'($signed({1'b0, mag_cur}) - $signed({3'b0, deadband_q}));
				mul_b = 20'($signed({1'b0, db_gain_q}));
			end
			OP_X: begin
				mul_a = 25'($signed({1'b0, angle_q}));
				mul_b = 20'($signed({1'b0, mag_trn}));
			end
			OP_X2: begin mul_a = 25'(x_q); mul_b = 20'(x_q); end
			OP_X3: begin mul_a = 25'(x2_q); mul_b = 20'(x_q); end
			OP_X5: begin mul_a = 25'(x3_q); mul_b = 20'(x2_q); end
			OP_T6: begin mul_a = 25'(x3_q); mul_b = 20'(KINV6); end
			OP_T120: begin mul_a = 25'(x5_q); mul_b = 20'(KINV120); end
			OP_G: begin mul_a = 25'(s_q); mul_b = 20'($signed({1'b0, gain_q})); end
			OP_INERT: begin mul_a = 25'(ninert_q); mul_b = 20'($signed({1'b0, halves})); end
			OP_Q1: begin mul_a = 25'(qs_q); mul_b = 20'(ONE - K010); end
			OP_Q2: begin mul_a = 25'(lim); mul_b = 20'(5 * K010); acc_en = 1'b1; end
			OP_A1: begin mul_a = 25'(trn2_q); mul_b = 20'($signed(mag_thr)); end
			OP_A2: begin
				mul_a = 25'(t_q);
				mul_b = 20'($signed({1'b0, high_q ? high_sens_q : low_sens_q}));
			end
			default: ;
		endcase
	end

	always_comb begin
		rnd = rsh_frac(prod_q);
		db_zero = (mag_cur <= {2'b0, deadband_q});
		db_r = (rnd > PROD_W'(ONE)) ? PROD_W'(ONE) : rnd;
		db_val = db_zero ? 16'sd0 : (db_src[15] ? -16'(db_r) : 16'(db_r));
		ia_sum = 24'(ia_q) + 24'(rsh1(prod_q));
		if (ia_sum > 24'sd2097151) ia_new = 22'sd2097151;
		else if (ia_sum < -24'sd2097152) ia_new = -22'sd2097152;
		else ia_new = ia_sum[21:0];
		q_r = rnd;
	end

	always_comb begin
		lft = 27'(thr_q) - 27'(ang_q);
		rgt = 27'(thr_q) + 27'(ang_q);
		if (lft > 27'(ONE)) begin
			if (quick_q) rgt = rgt - (lft - 27'(ONE));
			lft = 27'(ONE);
		end else if (rgt > 27'(ONE)) begin
			if (quick_q) lft = lft - (rgt - 27'(ONE));
			rgt = 27'(ONE);
		end else if (lft < -27'(ONE)) begin
			if (quick_q) rgt = rgt + (-lft - 27'(ONE));
			lft = -27'(ONE);
		end else if (rgt < -27'(ONE)) begin
			if (quick_q) lft = lft + (-rgt - 27'(ONE));
			rgt = -27'(ONE);
		end
		if (lft > 27'(ONE)) lft = 27'(ONE);
		else if (lft < -27'(ONE)) lft = -27'(ONE);
		if (rgt > 27'(ONE)) rgt = 27'(ONE);
		else if (rgt < -27'(ONE)) rgt = -27'(ONE);
	end

	// Configuration and carried state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= 14'd328;
			db_gain_q <= 15'd16718;
			low_sens_q <= 15'd16384;
			high_sens_q <= 15'd16384;
			angle_q <= 15'd25736;
			gain_q <= 18'd16384;
			prev_q <= '0;
			ia_q <= '0;
			qs_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_DEADBAND:  deadband_q <= cfg_data[13:0];
					REG_DB_GAIN:   db_gain_q <= cfg_data[14:0];
					REG_LOW_SENS:  low_sens_q <= cfg_data[14:0];
					REG_HIGH_SENS: high_sens_q <= cfg_data[14:0];
					REG_ANGLE:     angle_q <= cfg_data[14:0];
					REG_GAIN:      gain_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.wb) begin
				case (cmd.op)
					OP_DB_S: prev_q <= db_val;
					OP_INERT: begin
						if (ia_new > 22'sd16384) ia_q <= ia_new - 22'sd16384;
						else if (ia_new < -22'sd16384) ia_q <= ia_new + 22'sd16384;
						else ia_q <= '0;
					end
					OP_Q2: begin
						if (q_r > 48'sd131071) qs_q <= 18'sd131071;
						else if (q_r < -48'sd131072) qs_q <= -18'sd131072;
						else qs_q <= q_r[17:0];
					end
					OP_A2: begin
						if (qs_q > 18'sd16384) qs_q <= qs_q - 18'sd16384;
						else if (qs_q < -18'sd16384) qs_q <= qs_q + 18'sd16384;
						else qs_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// Per-transaction working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			thr_c_q <= clamp_one(in_thr);
			trn_c_q <= clamp_one(in_trn);
			quick_q <= in_user[0];
			high_q <= in_user[1];
		end
		if (cmd.mix) begin
			left_q <= lft[15:0];
			right_q <= rgt[15:0];
		end
		if (!cmd.wb) begin
			prod_q <= (acc_en ? prod_q : '0) + PROD_W'(mul_a * mul_b);
		end else begin
			case (cmd.op)
				OP_DB_T: thr_q <= db_val;
				OP_DB_S: begin
					trn_q <= db_val;
					ninert_q <= 18'(db_val) - 18'(prev_q);
				end
				OP_X: x_q <= rnd[17:0];
				OP_X2: x2_q <= rnd[17:0];
				OP_X3: x3_q <= rnd[18:0];
				OP_X5: x5_q <= rnd[20:0];
				OP_T6: t6_q <= rnd[18:0];
				OP_T120: s_q <= 19'(x_q) - t6_q + rnd[18:0];
				OP_G: sh_q <= trn_q[15] ? -rnd[20:0] : rnd[20:0];
				OP_INERT: begin
					trn2_q <= 24'(sh_q) + 24'(ia_new);
					ang_q <= 26'(24'(sh_q) + 24'(ia_new));
				end
				OP_A1: t_q <= rnd[23:0];
				OP_A2: ang_q <= rnd[25:0] - 26'(qs_q);
				default: ;
			endcase
		end
	end

endmodule
